@@ hw/rtl/scf_pkg.sv @@
// Shared types and constants for the scanline coverage fill block.
`default_nettype none
package scf_pkg;
    localparam int unsigned PixOne   = 256;
    localparam int unsigned SubFirst = 32;
    localparam int unsigned SubStep  = 64;
    localparam int unsigned SubLines = 4;
    localparam int unsigned AlphaMax = 255;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN_RD,
        ST_SCAN_TEST,
        ST_DIV,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SWEEP_RD,
        ST_SWEEP_PIX,
        ST_EMIT
    } t_state;

    // Divider request and response.
    typedef struct packed {
        logic               start;
        logic signed [32:0] num;
        logic signed [16:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [32:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

@@ hw/rtl/scf_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module scf_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire scf_pkg::t_div_req i_req,
    output scf_pkg::t_div_rsp      o_rsp
);
    import scf_pkg::*;

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [32:0] r_quo;
    logic [33:0] r_rem;
    logic [16:0] r_den;
    logic        r_neg;
    logic        r_done;

    logic [32:0] num_abs;
    logic [16:0] den_abs;
    logic [33:0] rem_sh;
    logic [33:0] rem_sub;

    assign num_abs = i_req.num[32] ? 33'(-i_req.num) : 33'(i_req.num);
    assign den_abs = i_req.den[16] ? 17'(-i_req.den) : 17'(i_req.den);
    assign rem_sh  = {r_rem[32:0], r_quo[32]};
    assign rem_sub = rem_sh - {17'd0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
                r_quo  <= num_abs;
                r_rem  <= '0;
                r_den  <= den_abs;
                r_neg  <= i_req.num[32] ^ i_req.den[16];
            end else if (r_busy) begin
                if (!rem_sub[33]) begin
                    r_rem <= rem_sub;
                    r_quo <= {r_quo[31:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[31:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule
`default_nettype wire

@@ hw/rtl/scanline_coverage_fill.sv @@
// An add item is handled while idle. A render item runs a clear pass over
// MAX_WIDTH accumulators, then per sub-scanline an edge scan with a serial
// divider run per crossing, an insertion sort of up to n*n/2 compare steps
// for n crossings and a sweep over each covered pixel, then one output per
// column. One item at a time. Reset empties the edge list and sets the width to 64.
`default_nettype none
module scanline_coverage_fill #(
    parameter int unsigned MAX_EDGES     = 256,
    parameter int unsigned MAX_CROSSINGS = 64,
    parameter int unsigned MAX_WIDTH     = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_mode,
    input  wire logic               i_start_new,
    input  wire logic signed [15:0] i_edge_x_start,
    input  wire logic signed [15:0] i_edge_y_start,
    input  wire logic signed [15:0] i_edge_x_end,
    input  wire logic signed [15:0] i_edge_y_end,
    input  wire logic [6:0]         i_row_index,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_coverage,
    output logic [5:0]              o_column,
    output logic                    o_last_in_row,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [6:0]         i_cfg_bitmap_width
);
    import scf_pkg::*;

    localparam int EW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_CROSSINGS);
    localparam int WW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int CCW = $clog2(MAX_CROSSINGS + 1);
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int WNW = CCW + 1;

    // Memories.
    logic [63:0] r_etab [MAX_EDGES];
    logic [16:0] r_xbuf [MAX_CROSSINGS];
    logic [10:0] r_acc  [MAX_WIDTH];

    t_state r_state, n_state;
    logic [6:0]      r_width_cfg;
    logic [ECW-1:0]  r_ecount;
    logic [ECW-1:0]  r_ei;
    logic [CCW-1:0]  r_nx;
    logic [CCW-1:0]  r_si;
    logic [CCW-1:0]  r_sj;
    logic [1:0]      r_k;
    logic [6:0]      r_row;
    logic [WCW-1:0]  r_w;
    logic [WCW-1:0]  r_col;
    logic [63:0]     r_erd;
    logic [16:0]     r_key;
    logic [16:0]     r_xrd;
    logic [16:0]     r_xa;
    logic signed [WNW-1:0] r_wind;
    logic signed [17:0] r_cpix;
    logic signed [17:0] r_cend;
    logic [10:0]     r_accrd;
    logic            r_ov;
    logic [7:0]      r_ocov;
    logic [5:0]      r_ocol;
    logic            r_olast;
    logic            r_sortmode; // 0: read key, 1: compare/shift
    logic            r_swph;     // sweep: 0 xa, 1 xb; pixel: 0 read acc, 1 write acc
    logic            r_pixph;    // pixel: 0 set range, 1 step; emit: 0 read acc, 1 out

    t_div_req div_req;
    t_div_rsp div_rsp;

    scf_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    // Current sample y.
    logic signed [17:0] ys;
    assign ys = 18'($signed({1'b0, r_row, 8'd0}) + 18'(SubFirst) + 18'(r_k) * 18'(SubStep));

    logic signed [15:0] ex0, ey0, ex1, ey1;
    assign ex0 = r_erd[63:48];
    assign ey0 = r_erd[47:32];
    assign ex1 = r_erd[31:16];
    assign ey1 = r_erd[15:0];
    logic hit;
    assign hit = (ey0 < ey1) ? (ys >= 18'(ey0) && ys < 18'(ey1))
                             : (ys >= 18'(ey1) && ys < 18'(ey0));

    logic signed [16:0] xnew;
    assign xnew = 17'(ex0) + div_rsp.quo[16:0];

    logic [6:0] wcl;
    always_comb begin
        if (r_width_cfg == 7'd0) wcl = 7'd1;
        else if (32'(r_width_cfg) > MAX_WIDTH) wcl = 7'(MAX_WIDTH);
        else wcl = r_width_cfg;
    end

    logic signed [17:0] xb_s, xa_s, lft, rgt, lo, hi, w_s;
    assign xa_s = 18'($signed(r_xa[16:1]));
    assign xb_s = 18'($signed(r_xrd[16:1]));
    assign w_s  = $signed(18'(r_w));
    assign lft  = r_cpix <<< 8;
    assign rgt  = (r_cpix + 18'sd1) <<< 8;
    assign lo   = (xa_s > lft) ? xa_s : lft;
    assign hi   = (xb_s < rgt) ? xb_s : rgt;

    logic scan_done, sweep_done, span_skip;
    assign scan_done  = (r_ei >= r_ecount) || (32'(r_nx) + 32'd1 >= MAX_CROSSINGS);
    assign sweep_done = (32'(r_si) + 32'd1 >= 32'(r_nx));
    assign span_skip  = (r_wind == '0) || (xb_s <= xa_s);

    always_comb begin
        n_state = r_state;
        div_req.start = 1'b0;
        div_req.num = 33'(17'(ex1) - 17'(ex0)) * 33'(ys - 18'(ey0));
        div_req.den = 17'(ey1) - 17'(ey0);
        unique case (r_state)
            ST_IDLE: if (i_valid && i_mode) n_state = ST_CLEAR;
            ST_CLEAR: if (r_col == WCW'(MAX_WIDTH - 1)) n_state = ST_SCAN_RD;
            ST_SCAN_RD: n_state = scan_done ? ST_SORT_RD : ST_SCAN_TEST;
            ST_SCAN_TEST: begin
                if (hit) begin
                    n_state = ST_DIV;
                    div_req.start = 1'b1;
                end else n_state = ST_SCAN_RD;
            end
            ST_DIV: if (div_rsp.done) n_state = ST_SCAN_RD;
            ST_SORT_RD: begin
                if (r_si >= r_nx) n_state = ST_SWEEP_RD;
                else if (r_sortmode) n_state = ST_SORT_CMP;
            end
            ST_SORT_CMP: n_state = ST_SORT_RD;
            ST_SWEEP_RD: begin
                if (sweep_done)
                    n_state = (r_k == 2'(SubLines - 1)) ? ST_EMIT : ST_SCAN_RD;
                else if (r_swph) n_state = ST_SWEEP_PIX;
            end
            ST_SWEEP_PIX: begin
                if (span_skip || (r_pixph && r_cpix > r_cend)) n_state = ST_SWEEP_RD;
            end
            ST_EMIT: if (r_ov && i_ready && r_olast) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width_cfg <= 7'd64;
            r_ecount    <= '0;
            r_ov        <= 1'b0;
            r_col       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_width_cfg <= i_cfg_bitmap_width;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid && !i_mode) begin
                        if (i_edge_y_start != i_edge_y_end &&
                            (i_start_new || 32'(r_ecount) < MAX_EDGES)) begin
                            r_etab[i_start_new ? EW'(0) : r_ecount[EW-1:0]] <=
                                {i_edge_x_start, i_edge_y_start, i_edge_x_end, i_edge_y_end};
                            r_ecount <= i_start_new ? ECW'(1) : r_ecount + ECW'(1);
                        end else if (i_start_new) r_ecount <= '0;
                    end
                    r_row <= i_row_index;
                    r_w   <= WCW'(wcl);
                    r_col <= '0;
                    r_k   <= '0;
                    r_ei  <= '0;
                    r_nx  <= '0;
                end
                ST_CLEAR: begin
                    r_acc[r_col[WW-1:0]] <= '0;
                    r_col <= (r_col == WCW'(MAX_WIDTH - 1)) ? '0 : r_col + WCW'(1);
                end
                ST_SCAN_RD: begin
                    r_erd <= r_etab[r_ei[EW-1:0]];
                    if (scan_done) begin
                        r_si <= CCW'(1);
                        r_sortmode <= 1'b0;
                    end
                end
                ST_SCAN_TEST: r_ei <= r_ei + ECW'(1);
                ST_DIV: if (div_rsp.done) begin
                    r_xbuf[r_nx[CW-1:0]] <= {xnew[15:0], ey1 > ey0};
                    r_nx <= r_nx + CCW'(1);
                end
                ST_SORT_RD: begin
                    // insertion sort, one compare/shift per step
                    if (r_si >= r_nx) begin
                        r_si <= '0;
                        r_swph <= 1'b0;
                        r_wind <= '0;
                    end else if (!r_sortmode) begin
                        r_key <= r_xbuf[r_si[CW-1:0]];
                        r_sj  <= r_si;
                        r_sortmode <= 1'b1;
                    end else begin
                        r_xrd <= r_xbuf[CW'(r_sj - CCW'(1))];
                    end
                end
                ST_SORT_CMP: begin
                    if (r_sj != '0 &&
                        $signed(r_xrd[16:1]) > $signed(r_key[16:1])) begin
                        r_xbuf[r_sj[CW-1:0]] <= r_xrd;
                        r_sj <= r_sj - CCW'(1);
                        if (r_sj == CCW'(1)) begin
                            r_xbuf[CW'(0)] <= r_key;
                            r_si <= r_si + CCW'(1);
                            r_sortmode <= 1'b0;
                        end
                    end else begin
                        r_xbuf[r_sj[CW-1:0]] <= r_key;
                        r_si <= r_si + CCW'(1);
                        r_sortmode <= 1'b0;
                    end
                end
                ST_SWEEP_RD: begin
                    if (sweep_done) begin
                        if (r_k == 2'(SubLines - 1)) begin
                            r_col <= '0;
                            r_pixph <= 1'b0;
                        end else begin
                            r_k <= r_k + 2'd1;
                            r_ei <= '0;
                            r_nx <= '0;
                        end
                    end else if (!r_swph) begin
                        r_xa <= r_xbuf[r_si[CW-1:0]];
                        r_swph <= 1'b1;
                    end else begin
                        r_xrd <= r_xbuf[CW'(r_si + CCW'(1))];
                        r_wind <= r_xa[0] ? r_wind + WNW'(1) : r_wind - WNW'(1);
                        r_swph <= 1'b0;
                        r_pixph <= 1'b0;
                    end
                end
                ST_SWEEP_PIX: begin
                    // skip empty spans; else set the pixel range, then read/add per pixel
                    if (span_skip) begin
                        r_si <= r_si + CCW'(1);
                    end else if (!r_pixph) begin
                        r_cpix <= (xa_s < 0) ? 18'sd0 : (xa_s >>> 8);
                        r_cend <= (((xb_s - 18'sd1) >>> 8) >= w_s)
                                  ? w_s - 18'sd1 : ((xb_s - 18'sd1) >>> 8);
                        r_pixph <= 1'b1;
                        r_swph <= 1'b0;
                    end else if (r_cpix > r_cend) begin
                        r_si <= r_si + CCW'(1);
                    end else if (!r_swph) begin
                        r_accrd <= r_acc[r_cpix[WW-1:0]];
                        r_swph <= 1'b1;
                    end else begin
                        if (hi > lo) r_acc[r_cpix[WW-1:0]] <= r_accrd + 11'(hi - lo);
                        r_cpix <= r_cpix + 18'sd1;
                        r_swph <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    if (!r_ov || i_ready) begin
                        if (r_ov && r_olast) r_ov <= 1'b0;
                        else if (!r_pixph) begin
                            r_accrd <= r_acc[r_col[WW-1:0]];
                            r_pixph <= 1'b1;
                            r_ov <= 1'b0;
                        end else begin
                            r_ocov  <= (r_accrd[10:2] > 9'(AlphaMax)) ? 8'(AlphaMax)
                                                                       : r_accrd[9:2];
                            r_ocol  <= r_col[5:0];
                            r_olast <= (r_col == r_w - WCW'(1));
                            r_ov    <= 1'b1;
                            r_col   <= r_col + WCW'(1);
                            r_pixph <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_coverage    = r_ocov;
    assign o_column      = r_ocol;
    assign o_last_in_row = r_olast;
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the scanline coverage fill block.
`default_nettype none
module tb_top;
    import scf_pkg::*;

    localparam int EdgeCap  = 256;
    localparam int CrossCap = 64;
    localparam int WidthCap = 64;
    localparam int CycleLimit = 20000000;

    typedef struct {
        logic [7:0] alpha;
        logic [5:0] col;
        logic       last;
    } t_pixel;

    class coverage_board;
        int     seg_x0[EdgeCap];
        int     seg_y0[EdgeCap];
        int     seg_x1[EdgeCap];
        int     seg_y1[EdgeCap];
        int     seg_count;
        int     width_reg;
        t_pixel pixel_q[$];
        int     errors;

        function new();
            seg_count = 0;
            width_reg = 64;
            errors    = 0;
        endfunction

        function int pix_floor(int x);
            return ((x + 65536) >>> 8) - 256;
        endfunction

        function void note_item(logic mode, logic start_new, shortint x0, shortint y0,
                                shortint x1, shortint y1, logic [6:0] row);
            int     acc[WidthCap];
            int     cx[CrossCap];
            bit     cd[CrossCap];
            int     w, n, y, lo, hi, wind, xa, xb, ca, cb, l, r, tx, j;
            bit     td;
            longint q;
            t_pixel p;
            if (!mode) begin
                if (start_new) seg_count = 0;
                if (y0 != y1 && seg_count < EdgeCap) begin
                    seg_x0[seg_count] = x0;
                    seg_y0[seg_count] = y0;
                    seg_x1[seg_count] = x1;
                    seg_y1[seg_count] = y1;
                    seg_count++;
                end
                return;
            end
            w = width_reg;
            if (w < 1) w = 1;
            if (w > WidthCap) w = WidthCap;
            foreach (acc[i]) acc[i] = 0;
            for (int k = 0; k < int'(SubLines); k++) begin
                y = int'(row) * int'(PixOne) + int'(SubFirst) + k * int'(SubStep);
                n = 0;
                for (int e = 0; e < seg_count && n + 1 < CrossCap; e++) begin
                    lo = (seg_y0[e] < seg_y1[e]) ? seg_y0[e] : seg_y1[e];
                    hi = (seg_y0[e] < seg_y1[e]) ? seg_y1[e] : seg_y0[e];
                    if (y < lo || y >= hi) continue;
                    q = (longint'(seg_x1[e] - seg_x0[e]) * longint'(y - seg_y0[e]))
                        / longint'(seg_y1[e] - seg_y0[e]);
                    cx[n] = seg_x0[e] + int'(q);
                    cd[n] = seg_y1[e] > seg_y0[e];
                    n++;
                end
                for (int i = 1; i < n; i++) begin
                    tx = cx[i];
                    td = cd[i];
                    j = i;
                    while (j > 0 && cx[j-1] > tx) begin
                        cx[j] = cx[j-1];
                        cd[j] = cd[j-1];
                        j--;
                    end
                    cx[j] = tx;
                    cd[j] = td;
                end
                wind = 0;
                for (int a = 0; a + 1 < n; a++) begin
                    wind += cd[a] ? 1 : -1;
                    if (wind == 0) continue;
                    xa = cx[a];
                    xb = cx[a+1];
                    if (xb <= xa) continue;
                    ca = pix_floor(xa);
                    cb = pix_floor(xb - 1);
                    if (ca < 0) ca = 0;
                    if (cb >= w) cb = w - 1;
                    for (int c = ca; c <= cb; c++) begin
                        l = (xa > c * 256) ? xa : c * 256;
                        r = (xb < (c + 1) * 256) ? xb : (c + 1) * 256;
                        if (r > l) acc[c] += r - l;
                    end
                end
            end
            for (int c = 0; c < w; c++) begin
                p.alpha = ((acc[c] >> 2) > int'(AlphaMax)) ? 8'(AlphaMax) : 8'(acc[c] >> 2);
                p.col   = 6'(c);
                p.last  = (c == w - 1);
                pixel_q.push_back(p);
            end
        endfunction

        function void check_result(logic [7:0] alpha, logic [5:0] col, logic last);
            t_pixel p;
            if (pixel_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel col=%0d alpha=%0d last=%0b",
                         $time, col, alpha, last);
                return;
            end
            p = pixel_q.pop_front();
            if (alpha !== p.alpha) begin
                errors++;
                $display("%0t: coverage col %0d expected %0d actual %0d",
                         $time, p.col, p.alpha, alpha);
            end
            if (col !== p.col) begin
                errors++;
                $display("%0t: column expected %0d actual %0d", $time, p.col, col);
            end
            if (last !== p.last) begin
                errors++;
                $display("%0t: last_in_row col %0d expected %0b actual %0b",
                         $time, p.col, p.last, last);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_mode;
    logic               i_start_new;
    logic signed [15:0] i_edge_x_start;
    logic signed [15:0] i_edge_y_start;
    logic signed [15:0] i_edge_x_end;
    logic signed [15:0] i_edge_y_end;
    logic [6:0]         i_row_index;
    logic               o_valid;
    logic               i_ready;
    logic [7:0]         o_coverage;
    logic [5:0]         o_column;
    logic               o_last_in_row;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [6:0]         i_cfg_bitmap_width;

    coverage_board board = new();
    bit            calm = 0;
    int            cycles = 0;
    int            items_sent = 0;

    scanline_coverage_fill i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_mode             (i_mode),
        .i_start_new        (i_start_new),
        .i_edge_x_start     (i_edge_x_start),
        .i_edge_y_start     (i_edge_y_start),
        .i_edge_x_end       (i_edge_x_end),
        .i_edge_y_end       (i_edge_y_end),
        .i_row_index        (i_row_index),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_coverage         (o_coverage),
        .o_column           (o_column),
        .o_last_in_row      (o_last_in_row),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_bitmap_width (i_cfg_bitmap_width)
    );

    initial i_clk = 0;
    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random back-pressure unless calm, check every accepted pixel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) board.check_result(o_coverage, o_column, o_last_in_row);
            i_ready <= calm || ($urandom_range(99) >= 35);
        end
    end

    task automatic send_item(logic mode, logic start_new, shortint x0, shortint y0,
                             shortint x1, shortint y1, logic [6:0] row);
        if (!calm && $urandom_range(99) < 35) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= mode;
        i_start_new    <= start_new;
        i_edge_x_start <= x0;
        i_edge_y_start <= y0;
        i_edge_x_end   <= x1;
        i_edge_y_end   <= y1;
        i_row_index    <= row;
        do @(posedge i_clk); while (!o_ready);
        board.note_item(mode, start_new, x0, y0, x1, y1, row);
        items_sent++;
    endtask

    task automatic push_segment(logic start_new, int x0, int y0, int x1, int y1);
        send_item(1'b0, start_new, shortint'(x0), shortint'(y0), shortint'(x1),
                  shortint'(y1), 7'($urandom));
    endtask

    task automatic render_row(int row);
        send_item(1'b1, 1'($urandom), shortint'($urandom), shortint'($urandom),
                  shortint'($urandom), shortint'($urandom), 7'(row));
    endtask

    // stop sending, wait for every pixel, then let a trailing add finish
    task automatic settle();
        i_valid <= 1'b0;
        while (board.pixel_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_width(logic [6:0] w);
        i_cfg_valid        <= 1'b1;
        i_cfg_bitmap_width <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.width_reg = w;
        i_cfg_valid <= 1'b0;
    endtask

    // random closed polygon around pixel row r, then render rows nearby
    task automatic random_polygon(int w);
        int vx[8];
        int vy[8];
        int nv, r, fresh;
        nv    = $urandom_range(3, 7);
        r     = $urandom_range(0, 127);
        fresh = ($urandom_range(99) < 80);
        for (int i = 0; i < nv; i++) begin
            vx[i] = $urandom_range(0, w * 256 + 800) - 400;
            vy[i] = r * 256 + $urandom_range(0, 1100) - 400;
            if (vy[i] > 32767) vy[i] = 32767;
            if ($urandom_range(9) == 0) vy[i] = vy[(i + nv - 1) % nv];
        end
        for (int i = 0; i < nv; i++)
            push_segment(fresh && i == 0, vx[i], vy[i], vx[(i + 1) % nv], vy[(i + 1) % nv]);
        repeat ($urandom_range(1, 3)) begin
            r = r + $urandom_range(0, 3) - 1;
            render_row(r < 0 ? 0 : (r > 127 ? 127 : r));
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_mode             = 1'b0;
        i_start_new        = 1'b0;
        i_edge_x_start     = '0;
        i_edge_y_start     = '0;
        i_edge_x_end       = '0;
        i_edge_y_end       = '0;
        i_row_index        = '0;
        i_cfg_valid        = 1'b0;
        i_cfg_bitmap_width = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, extremes, horizontal, a rectangle, row extremes
        render_row(0);
        push_segment(1, -32768, -32768, 32767, 32767);
        push_segment(0, 32767, 32767, -32768, -32768);
        render_row(127);
        push_segment(1, 0, 0, 512, 0);
        render_row(0);
        push_segment(1, 256, 0, 256, 512);
        push_segment(0, 1024, 512, 1024, 0);
        push_segment(0, 0, 256, 16384, 256);
        render_row(0);
        render_row(1);
        push_segment(0, -512, 0, -512, 512);
        push_segment(0, 17000, 512, 17000, 0);
        render_row(0);
        push_segment(1, 100, 0, 16000, 32767);
        push_segment(0, 16300, 32767, 300, 0);
        push_segment(0, 300, 0, 300, 32767);
        push_segment(0, 50, 32767, 50, 0);
        render_row(0);
        render_row(64);
        render_row(127);
        settle();

        // crossing cap: more edges than crossings, every edge spans rows 0..3
        for (int i = 0; i < CrossCap + 4; i++)
            push_segment(i == 0, (i * 61) % 16640, (i % 2) ? 1024 : 0, (i * 37) % 16640,
                         (i % 2) ? 0 : 1024);
        render_row(0);
        render_row(3);
        render_row(4);
        settle();

        // width phases, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            logic [6:0] wsel;
            int         weff;
            int         goal;
            case (ph)
                0: wsel = 7'd1;
                1: wsel = 7'd0;
                2: wsel = 7'd127;
                3: wsel = 7'($urandom_range(2, 63));
                default: wsel = 7'd64;
            endcase
            weff = (wsel == 0) ? 1 : ((wsel > 64) ? 64 : wsel);
            set_width(wsel);
            goal = items_sent + 14;
            while (items_sent < goal) begin
                calm = (ph == 2);
                case ($urandom_range(9))
                    0: push_segment(1'($urandom_range(1)), int'($urandom), int'($urandom),
                                    int'($urandom), int'($urandom));
                    1: render_row($urandom_range(0, 127));
                    default: random_polygon(weff);
                endcase
            end
            calm = 0;
            settle();
        end

        while (board.pixel_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
